// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL of the FM demodulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLKRST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on every rising clock edge, also during reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/fmd_pkg.sv -----
// Package with constants and register indexes of the FM demodulator.
package fmd_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned DcFreeW = SampleW + 1;
  localparam int unsigned ProdW   = 2 * DcFreeW;
  localparam int unsigned AccW    = 32;
  localparam int unsigned AudioW  = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 6;

  localparam logic signed [AccW:0] MidScale = 33'sd2048;
  localparam logic signed [AccW:0] OutMax   = 33'sd4095;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DC_SHIFT    = 3'd0,
    CFG_DISC_SHIFT  = 3'd1,
    CFG_LP_SHIFT    = 3'd2,
    CFG_DEEMP_SHIFT = 3'd3,
    CFG_SWAP_IQ     = 3'd4
  } cfg_idx_e;

endpackage

// ----- hdl/fm_iq_demodulator.sv -----
// FM demodulator: pipeline of DC blockers, cross-product discriminator and IIR filters.
// An accepted transaction passes s1 to s6 and the output register to audio_out_o.
// One I/Q transaction per cycle unless stalled; feedback loops close in one stage.
// A one-entry skid register at the input keeps in_stall_o a registered signal.
// Reset clears the filter state and pipeline valids and loads the register defaults.
module fm_iq_demodulator (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [fmd_pkg::SampleW-1:0]      i_sample_i,
  input  logic signed [fmd_pkg::SampleW-1:0]      q_sample_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic        [fmd_pkg::AudioW-1:0]       audio_out_o,
  input  logic                                    cfg_we_i,
  input  logic        [fmd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic        [fmd_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned SW = fmd_pkg::SampleW;
  localparam int unsigned DW = fmd_pkg::DcFreeW;
  localparam int unsigned PW = fmd_pkg::ProdW;
  localparam int unsigned AW = fmd_pkg::AccW;

  // Configuration registers.
  logic [3:0] dc_shift_q, lp_shift_q, deemp_shift_q;
  logic [5:0] disc_shift_q;
  logic       swap_iq_q;

  // Handshake and pipeline control.
  logic adv, in_acc;
  logic skid_valid_q, s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic s5_valid_q, s6_valid_q, out_valid_q;

  // Payload registers.
  logic signed [SW-1:0] skid_i_q, skid_q_q, s1_i_q, s1_q_q, src_i, src_q;
  logic signed [DW-1:0] s2_i_q, s2_q_q, s2_ilast_q, s2_qlast_q;
  logic signed [PW-1:0] s3_pi_q, s3_pq_q;
  logic signed [AW-1:0] s4_d_q;
  logic [fmd_pkg::AudioW-1:0] audio_q;

  // Filter state.
  logic signed [SW-1:0] i_off_q, q_off_q, i_off_d, q_off_d;
  logic signed [DW-1:0] i_last_q, q_last_q, i_free, q_free;
  logic signed [AW-1:0] lp_acc_q, lp_acc_d, de_acc_q, de_acc_d;

  // Combinational intermediates.
  logic signed [DW-1:0] i_diff, q_diff, i_step, q_step, i_osum, q_osum;
  logic signed [PW:0]   pd, pd_sh;
  logic signed [AW:0]   lp_diff, lp_step, de_diff, de_step, audio_sum;
  logic signed [AW+1:0] lp_sum, de_sum;
  logic [fmd_pkg::AudioW-1:0] audio_d;

  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign audio_out_o = audio_q;

  assign src_i = skid_valid_q ? skid_i_q : i_sample_i;
  assign src_q = skid_valid_q ? skid_q_q : q_sample_i;

  // DC blockers.
  always_comb begin
    i_diff  = DW'(s1_i_q) - DW'(i_off_q);
    q_diff  = DW'(s1_q_q) - DW'(q_off_q);
    i_step  = i_diff >>> dc_shift_q;
    q_step  = q_diff >>> dc_shift_q;
    i_osum  = DW'(i_off_q) + i_step;
    q_osum  = DW'(q_off_q) + q_step;
    i_off_d = i_osum[SW-1:0];
    q_off_d = q_osum[SW-1:0];
    i_free  = DW'(s1_i_q) - DW'(i_off_d);
    q_free  = DW'(s1_q_q) - DW'(q_off_d);
  end

  // Discriminator scaling and the two IIR stages.
  always_comb begin
    pd       = (PW+1)'(s3_pi_q) - (PW+1)'(s3_pq_q);
    pd_sh    = pd >>> disc_shift_q;
    lp_diff  = (AW+1)'(s4_d_q) - (AW+1)'(lp_acc_q);
    lp_step  = lp_diff >>> lp_shift_q;
    lp_sum   = (AW+2)'(lp_acc_q) + (AW+2)'(lp_step);
    lp_acc_d = lp_sum[AW-1:0];
    de_diff  = (AW+1)'(lp_acc_q) - (AW+1)'(de_acc_q);
    de_step  = de_diff >>> deemp_shift_q;
    de_sum   = (AW+2)'(de_acc_q) + (AW+2)'(de_step);
    de_acc_d = de_sum[AW-1:0];
  end

  // Offset to midscale and saturate for the DAC.
  always_comb begin
    audio_sum = fmd_pkg::MidScale + (AW+1)'(de_acc_q);
    if (audio_sum < 0) begin
      audio_d = '0;
    end else if (audio_sum > fmd_pkg::OutMax) begin
      audio_d = '1;
    end else begin
      audio_d = audio_sum[fmd_pkg::AudioW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_shift_q    <= 4'd10;
      disc_shift_q  <= 6'd18;
      lp_shift_q    <= 4'd4;
      deemp_shift_q <= 4'd5;
      swap_iq_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fmd_pkg::CFG_DC_SHIFT:    dc_shift_q    <= cfg_data_i[3:0];
        fmd_pkg::CFG_DISC_SHIFT:  disc_shift_q  <= cfg_data_i[5:0];
        fmd_pkg::CFG_LP_SHIFT:    lp_shift_q    <= cfg_data_i[3:0];
        fmd_pkg::CFG_DEEMP_SHIFT: deemp_shift_q <= cfg_data_i[3:0];
        fmd_pkg::CFG_SWAP_IQ:     swap_iq_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      s4_valid_q   <= 1'b0;
      s5_valid_q   <= 1'b0;
      s6_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (adv) begin
      skid_valid_q <= 1'b0;
      s1_valid_q   <= skid_valid_q || in_acc;
      s2_valid_q   <= s1_valid_q;
      s3_valid_q   <= s2_valid_q;
      s4_valid_q   <= s3_valid_q;
      s5_valid_q   <= s4_valid_q;
      s6_valid_q   <= s5_valid_q;
      out_valid_q  <= s6_valid_q;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_off_q  <= '0;
      q_off_q  <= '0;
      i_last_q <= '0;
      q_last_q <= '0;
      lp_acc_q <= '0;
      de_acc_q <= '0;
    end else if (adv) begin
      if (s1_valid_q) begin
        i_off_q  <= i_off_d;
        q_off_q  <= q_off_d;
        i_last_q <= i_free;
        q_last_q <= q_free;
      end
      if (s4_valid_q) begin
        lp_acc_q <= lp_acc_d;
      end
      if (s5_valid_q) begin
        de_acc_q <= de_acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && in_acc) begin
      skid_i_q <= i_sample_i;
      skid_q_q <= q_sample_i;
    end
    if (adv) begin
      s1_i_q     <= swap_iq_q ? src_q : src_i;
      s1_q_q     <= swap_iq_q ? src_i : src_q;
      s2_i_q     <= i_free;
      s2_q_q     <= q_free;
      s2_ilast_q <= i_last_q;
      s2_qlast_q <= q_last_q;
      s3_pi_q    <= PW'(s2_i_q) * PW'(s2_qlast_q);
      s3_pq_q    <= PW'(s2_q_q) * PW'(s2_ilast_q);
      s4_d_q     <= pd_sh[AW-1:0];
      audio_q    <= audio_d;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_CLKRST(a_skid_fills_on_stall, $rose(skid_valid_q) |-> $past(!adv && in_acc), "bad skid")
  `ASSERT_CLKRST(a_accept_enters_pipe, (in_acc && adv) |=> s1_valid_q, "transaction lost")
  `ASSERT_CLKRST(a_out_from_last_stage, $rose(out_valid_q) |-> $past(s6_valid_q), "stray result")
  `ASSERT_CLK(a_reset_clears_out, !rst_ni |-> !out_valid_o && !in_stall_o, "active in reset")

endmodule
